[rtl/core/bmq_pkg.sv]
// Shared types and constants of the bitmap multiqueue ready queue.
// No dependencies; every other file of the block but bmq_ram imports this package.
`default_nettype none

package bmq_pkg;

    localparam int OPCODE_W = 2;
    localparam int THREAD_W = 6;
    localparam int LEVEL_W  = 5;

    // Operation codes; any other code only reports the best thread
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;

    // Update broadcast from the sequencer to the row of level cells
    typedef struct packed {
        logic                upd;
        logic [LEVEL_W-1:0]  level;
        logic                head_we;
        logic [THREAD_W-1:0] head;
        logic                tail_we;
        logic [THREAD_W-1:0] tail;
        logic                set_ne;
        logic                clr_ne;
    } bmq_cell_cmd_t;

    // Lookup of one level, handed along the row
    typedef struct packed {
        logic                nonempty;
        logic [THREAD_W-1:0] head;
        logic [THREAD_W-1:0] tail;
    } bmq_look_t;

    // Best-thread search, handed along the row from level 0 upward
    typedef struct packed {
        logic                found;
        logic [THREAD_W-1:0] thread;
        logic [LEVEL_W-1:0]  level;
    } bmq_best_t;

endpackage

`default_nettype wire

[rtl/core/bmq_in_if.sv]
// Request channel of the ready queue: valid/ready plus one operation.
// Depends on bmq_pkg for field widths.
`default_nettype none

interface bmq_in_if import bmq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [THREAD_W-1:0] thread_id;
    logic [LEVEL_W-1:0]  priority_level;

    modport source (output valid, output opcode, output thread_id,
                    output priority_level, input ready);
    modport sink   (input valid, input opcode, input thread_id,
                    input priority_level, output ready);
endinterface

`default_nettype wire

[rtl/core/bmq_out_if.sv]
// Result channel of the ready queue: valid/ready plus status and best thread.
// Depends on bmq_pkg for field widths.
`default_nettype none

interface bmq_out_if import bmq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic                best_valid;
    logic [THREAD_W-1:0] best_thread;
    logic [LEVEL_W-1:0]  best_level;

    modport source (output valid, output status, output best_valid,
                    output best_thread, output best_level, input ready);
    modport sink   (input valid, input status, input best_valid,
                    input best_thread, input best_level, output ready);
endinterface

`default_nettype wire

[rtl/core/bitmap_multiqueue_ready_queue_top.sv]
// Top level of the bitmap multiqueue ready queue: sequencer, thread stores
// and the row of level cells. Depends on bmq_pkg, bmq_in_if, bmq_out_if,
// bmq_ram and bmq_level_cell.
//
// Ready queue with NUM_LEVELS priority levels for NUM_THREADS threads. Each
// level is a cell holding head, tail and a non-empty flag; the cells form a
// row that hands a level lookup and the best-thread search from level 0
// upward. Per-thread links and the queued flag with the thread's level live
// in three RAMs. From its transfer to its result in the output register an
// operation goes through these steps: the registered RAM read at the thread
// is taken at the transfer edge, then cells and RAMs are updated, then the
// best-thread search over the updated row is loaded into the output
// register, a step that waits while it still holds an untaken result. A new
// request is taken while a result waits in the output register, but not
// before the last result has been loaded into it. After reset a clearing
// pass marks every thread as not queued; no request is taken during it.
`default_nettype none

module bitmap_multiqueue_ready_queue_top import bmq_pkg::*; #(
    parameter int NUM_THREADS = 64,
    parameter int NUM_LEVELS  = 32
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bmq_in_if.sink    req,
    bmq_out_if.source rsp
);

    localparam int TW     = $clog2(NUM_THREADS);
    localparam int INFO_W = 1 + LEVEL_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] state_reg, state_next;

    // Clearing pass over the thread info store
    logic          clearing_reg, clearing_next;
    logic [TW-1:0] clr_cnt_reg, clr_cnt_next;

    // Latched request
    logic [OPCODE_W-1:0] op_reg;
    logic [THREAD_W-1:0] tid_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic                status_reg, status_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic                out_status_reg;
    logic                out_bvalid_reg;
    logic [THREAD_W-1:0] out_bthread_reg;
    logic [LEVEL_W-1:0]  out_blevel_reg;

    // RAM ports
    logic                rd_ok;
    logic [TW-1:0]       rd_addr;
    logic                info_we;
    logic [TW-1:0]       info_waddr;
    logic [INFO_W-1:0]   info_wdata;
    logic [INFO_W-1:0]   info_rdata;
    logic                next_we;
    logic [TW-1:0]       next_waddr;
    logic [THREAD_W-1:0] next_wdata;
    logic [THREAD_W-1:0] next_rdata;
    logic                prev_we;
    logic [TW-1:0]       prev_waddr;
    logic [THREAD_W-1:0] prev_wdata;
    logic [THREAD_W-1:0] prev_rdata;

    // Decode of the executing operation
    logic                in_xfer;
    logic                t_ok;
    logic                lvl_ok;
    logic                queued;
    logic [LEVEL_W-1:0]  tlevel;
    logic                is_add;
    logic                is_rem;
    logic                do_add;
    logic                do_rem;
    logic                at_head;
    logic                at_tail;
    logic [LEVEL_W-1:0]  look_level;
    bmq_look_t           look_res;
    bmq_best_t           best_res;
    bmq_cell_cmd_t       cmd;
    logic                out_load;

    bmq_look_t look_chain [NUM_LEVELS+1];
    bmq_best_t best_chain [NUM_LEVELS+1];

    assign req.ready = (state_reg == S_IDLE) && !clearing_reg;
    assign in_xfer   = req.valid && req.ready;

    // Read the thread stores at the requested thread, at address 0 if out of range
    assign rd_ok   = {5'd0, req.thread_id} < 11'(NUM_THREADS);
    assign rd_addr = rd_ok ? TW'(req.thread_id) : '0;

    assign t_ok   = {5'd0, tid_reg} < 11'(NUM_THREADS);
    assign lvl_ok = {1'b0, lvl_reg} < 6'(NUM_LEVELS);
    assign queued = info_rdata[INFO_W-1];
    assign tlevel = info_rdata[LEVEL_W-1:0];

    assign is_add = (op_reg == OP_ADD);
    assign is_rem = (op_reg == OP_REMOVE);
    assign do_add = (state_reg == S_EXEC) && is_add && t_ok && lvl_ok && !queued;
    assign do_rem = (state_reg == S_EXEC) && is_rem && t_ok && queued;

    assign look_level = is_add ? lvl_reg : tlevel;
    assign look_res   = look_chain[NUM_LEVELS];
    assign best_res   = best_chain[NUM_LEVELS];
    assign at_head    = (look_res.head == tid_reg);
    assign at_tail    = (look_res.tail == tid_reg);

    assign status_next = (is_add && !do_add) || (is_rem && !do_rem);

    // Build the cell update and the RAM writes for this operation
    always_comb
    begin
        cmd        = '0;
        cmd.level  = look_level;
        info_we    = 1'b0;
        info_waddr = TW'(tid_reg);
        info_wdata = '0;
        next_we    = 1'b0;
        next_waddr = TW'(look_res.tail);
        next_wdata = tid_reg;
        prev_we    = 1'b0;
        prev_waddr = TW'(tid_reg);
        prev_wdata = look_res.tail;
        if (do_add)
        begin
            // Append at the tail; an empty level gets the thread as head too
            cmd.upd     = 1'b1;
            cmd.head_we = !look_res.nonempty;
            cmd.head    = tid_reg;
            cmd.tail_we = 1'b1;
            cmd.tail    = tid_reg;
            cmd.set_ne  = 1'b1;
            info_we     = 1'b1;
            info_wdata  = {1'b1, lvl_reg};
            next_we     = look_res.nonempty;
            prev_we     = look_res.nonempty;
        end
        else if (do_rem)
        begin
            // Unlink from wherever the thread sits in its level
            cmd.upd    = 1'b1;
            info_we    = 1'b1;
            info_wdata = {1'b0, tlevel};
            if (at_head && at_tail)
            begin
                cmd.clr_ne = 1'b1;
            end
            else if (at_head)
            begin
                cmd.head_we = 1'b1;
                cmd.head    = next_rdata;
            end
            else if (at_tail)
            begin
                cmd.tail_we = 1'b1;
                cmd.tail    = prev_rdata;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = TW'(prev_rdata);
                next_wdata = next_rdata;
                prev_we    = 1'b1;
                prev_waddr = TW'(next_rdata);
                prev_wdata = prev_rdata;
            end
        end
        else if (clearing_reg)
        begin
            // Mark one thread as not queued per cycle after reset
            info_we    = 1'b1;
            info_waddr = clr_cnt_reg;
            info_wdata = '0;
        end
    end

    // Thread stores
    bmq_ram #(.WIDTH(INFO_W), .DEPTH(NUM_THREADS)) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (rd_addr),
        .rdata (info_rdata)
    );

    bmq_ram #(.WIDTH(THREAD_W), .DEPTH(NUM_THREADS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    bmq_ram #(.WIDTH(THREAD_W), .DEPTH(NUM_THREADS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    // Row of level cells
    assign look_chain[0] = '0;
    assign best_chain[0] = '0;

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_cell
        bmq_level_cell #(.CELL_IDX(g)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .look_level (look_level),
            .look_in    (look_chain[g]),
            .look_out   (look_chain[g+1]),
            .best_in    (best_chain[g]),
            .best_out   (best_chain[g+1])
        );
    end

    // Sequencer and clearing pass
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == TW'(NUM_THREADS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // Hold the request and its status
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= req.opcode;
            tid_reg <= req.thread_id;
            lvl_reg <= req.priority_level;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_next;
        end
    end

    // Output register: load on a finished item, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= status_reg;
            out_bvalid_reg  <= best_res.found;
            out_bthread_reg <= best_res.thread;
            out_blevel_reg  <= best_res.level;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.best_valid  = out_bvalid_reg;
    assign rsp.best_thread = out_bthread_reg;
    assign rsp.best_level  = out_blevel_reg;

endmodule

`default_nettype wire

[rtl/core/bmq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/bmq_level_cell.sv]
// One priority level of the ready queue: head, tail and non-empty flag.
// Depends on bmq_pkg; instantiated in a row by the top level.
`default_nettype none

module bmq_level_cell import bmq_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmq_cell_cmd_t      cmd,
    input  wire logic [LEVEL_W-1:0] look_level,
    input  wire bmq_look_t          look_in,
    output bmq_look_t               look_out,
    input  wire bmq_best_t          best_in,
    output bmq_best_t               best_out
);

    localparam logic [LEVEL_W-1:0] MY_LEVEL = LEVEL_W'(CELL_IDX);

    logic                ne_reg;
    logic [THREAD_W-1:0] head_reg;
    logic [THREAD_W-1:0] tail_reg;
    logic                hit;

    assign hit = cmd.upd && (cmd.level == MY_LEVEL);

    // Non-empty flag: control state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg <= 1'b0;
        end
        else if (hit && cmd.set_ne)
        begin
            ne_reg <= 1'b1;
        end
        else if (hit && cmd.clr_ne)
        begin
            ne_reg <= 1'b0;
        end
    end

    // Head and tail pointers
    always_ff @(posedge clk)
    begin
        if (hit && cmd.head_we)
        begin
            head_reg <= cmd.head;
        end
        if (hit && cmd.tail_we)
        begin
            tail_reg <= cmd.tail;
        end
    end

    // Replace the lookup with this level's entry when it is the one asked for
    always_comb
    begin
        look_out = look_in;
        if (look_level == MY_LEVEL)
        begin
            look_out.nonempty = ne_reg;
            look_out.head     = head_reg;
            look_out.tail     = tail_reg;
        end
    end

    // Claim the best slot if no more urgent level already did
    always_comb
    begin
        best_out = best_in;
        if (!best_in.found && ne_reg)
        begin
            best_out.found  = 1'b1;
            best_out.thread = head_reg;
            best_out.level  = MY_LEVEL;
        end
    end

endmodule

`default_nettype wire
